@@ sv/bvfs_pkg.sv @@
// Shared constants, payload types and pipeline structs for the vector field sampler.
package bvfs_pkg;

   localparam int GRID_WIDTH  = 64;
   localparam int GRID_HEIGHT = 64;
   localparam int FRAC_BITS   = 8;

   localparam int DATA_W = 16;
   localparam int CELL_W = DATA_W - FRAC_BITS;
   localparam int X_BITS = $clog2(GRID_WIDTH);
   localparam int Y_BITS = $clog2(GRID_HEIGHT);

   // The grid is split over four banks by the parity of x and y, so the four
   // neighbors of a bilinear sample always sit in four different banks.
   localparam int BANK_COUNT  = 4;
   localparam int BANK_COL_W  = (GRID_WIDTH <= 2) ? 1 : $clog2((GRID_WIDTH + 1) / 2);
   localparam int BANK_ROW_W  = (GRID_HEIGHT <= 2) ? 1 : $clog2((GRID_HEIGHT + 1) / 2);
   localparam int BANK_ADDR_W = BANK_COL_W + BANK_ROW_W;
   localparam int BANK_DEPTH  = 1 << BANK_ADDR_W;
   localparam int RAM_W       = 2 * DATA_W;

   localparam int WT_W   = FRAC_BITS + 1;
   localparam int PROD_W = DATA_W + WT_W + 1;
   localparam int ROW_W  = DATA_W + FRAC_BITS;
   localparam int PSUM_W = ROW_W + WT_W + 1;
   localparam int SUM_W  = DATA_W + 2 * FRAC_BITS;

   localparam logic [WT_W-1:0]  ONE_FIX    = WT_W'(1) << FRAC_BITS;
   localparam logic [SUM_W-1:0] TRUNC_BIAS = SUM_W'((1 << (2 * FRAC_BITS)) - 1);

   localparam int CMDQ_DEPTH = 4;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
   localparam int RSPQ_DEPTH = 8;
   localparam int RSPQ_PTR_W = $clog2(RSPQ_DEPTH);
   localparam int RSPQ_CNT_W = $clog2(RSPQ_DEPTH + 1);

   typedef enum logic [1:0] {
      ACT_WRITE    = 2'd0,
      ACT_NEAREST  = 2'd1,
      ACT_BILINEAR = 2'd2
   } act_type;

   typedef struct packed {
      logic [1:0]               action;
      logic signed [DATA_W-1:0] pos_x;
      logic signed [DATA_W-1:0] pos_y;
      logic signed [DATA_W-1:0] value_x;
      logic signed [DATA_W-1:0] value_y;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] vec_x;
      logic signed [DATA_W-1:0] vec_y;
      logic                     inside_res;
   } rsp_type;

   typedef struct packed {
      act_type                  act;
      logic                     in_bounds;
      logic [X_BITS-1:0]        x0;
      logic [Y_BITS-1:0]        y0;
      logic [FRAC_BITS-1:0]     tx;
      logic [FRAC_BITS-1:0]     ty;
      logic signed [DATA_W-1:0] value_x;
      logic signed [DATA_W-1:0] value_y;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_link_type;

   typedef struct packed {
      act_type              act;
      logic                 in_bounds;
      logic                 x_odd;
      logic                 y_odd;
      logic [FRAC_BITS-1:0] tx;
      logic [FRAC_BITS-1:0] ty;
   } meta_type;

   // Corner order: 0 = (x0,y0), 1 = (x0+1,y0), 2 = (x0,y0+1), 3 = (x0+1,y0+1).
   typedef struct packed {
      logic                                valid;
      meta_type                            meta;
      logic [BANK_COUNT-1:0][RAM_W-1:0]    corner;
   } samp_type;

endpackage

@@ sv/bvfs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bvfs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/bvfs_front.sv @@
// Front end: classifies incoming items and holds them in a short command queue.
module bvfs_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  bvfs_pkg::req_type     req_data,
   input  logic                  cmd_pop,
   output bvfs_pkg::cmd_link_type cmd_link
);

   logic signed [bvfs_pkg::CELL_W-1:0] cell_x;
   logic signed [bvfs_pkg::CELL_W-1:0] cell_y;
   logic [bvfs_pkg::CELL_W-2:0]        mag_x;
   logic [bvfs_pkg::CELL_W-2:0]        mag_y;
   logic                               grid_x;
   logic                               grid_y;
   logic                               lerp_x;
   logic                               lerp_y;
   logic                               accept;
   bvfs_pkg::cmd_type                  cmd_in;

   bvfs_pkg::cmd_type                  cmdq_ff [bvfs_pkg::CMDQ_DEPTH];
   logic [bvfs_pkg::CMDQ_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [bvfs_pkg::CMDQ_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [bvfs_pkg::CMDQ_CNT_W-1:0]    count_ff, count_in;

   // The cell of a position is its floor, which is the arithmetic shift of the
   // fixed-point value; the sign bit tells a negative cell at once.
   assign cell_x = req_data.pos_x[bvfs_pkg::DATA_W-1:bvfs_pkg::FRAC_BITS];
   assign cell_y = req_data.pos_y[bvfs_pkg::DATA_W-1:bvfs_pkg::FRAC_BITS];
   assign mag_x  = cell_x[bvfs_pkg::CELL_W-2:0];
   assign mag_y  = cell_y[bvfs_pkg::CELL_W-2:0];

   assign grid_x = !cell_x[bvfs_pkg::CELL_W-1]
                   && (32'(mag_x) < 32'(bvfs_pkg::GRID_WIDTH));
   assign grid_y = !cell_y[bvfs_pkg::CELL_W-1]
                   && (32'(mag_y) < 32'(bvfs_pkg::GRID_HEIGHT));
   assign lerp_x = !cell_x[bvfs_pkg::CELL_W-1]
                   && (32'(mag_x) < 32'(bvfs_pkg::GRID_WIDTH - 1));
   assign lerp_y = !cell_y[bvfs_pkg::CELL_W-1]
                   && (32'(mag_y) < 32'(bvfs_pkg::GRID_HEIGHT - 1));

   always_comb begin
      cmd_in.act       = bvfs_pkg::ACT_WRITE;
      cmd_in.in_bounds = 1'b0;
      cmd_in.x0        = bvfs_pkg::X_BITS'(mag_x);
      cmd_in.y0        = bvfs_pkg::Y_BITS'(mag_y);
      cmd_in.tx        = req_data.pos_x[bvfs_pkg::FRAC_BITS-1:0];
      cmd_in.ty        = req_data.pos_y[bvfs_pkg::FRAC_BITS-1:0];
      cmd_in.value_x   = req_data.value_x;
      cmd_in.value_y   = req_data.value_y;
      case (req_data.action)
         bvfs_pkg::ACT_WRITE: begin
            cmd_in.act       = bvfs_pkg::ACT_WRITE;
            cmd_in.in_bounds = grid_x && grid_y;
         end
         bvfs_pkg::ACT_NEAREST: begin
            cmd_in.act       = bvfs_pkg::ACT_NEAREST;
            cmd_in.in_bounds = grid_x && grid_y;
         end
         bvfs_pkg::ACT_BILINEAR: begin
            cmd_in.act       = bvfs_pkg::ACT_BILINEAR;
            cmd_in.in_bounds = lerp_x && lerp_y;
         end
         default: begin
            // An unused action behaves as a write that falls outside the grid.
            cmd_in.act       = bvfs_pkg::ACT_WRITE;
            cmd_in.in_bounds = 1'b0;
         end
      endcase
   end

   assign full   = (count_ff == bvfs_pkg::CMDQ_CNT_W'(bvfs_pkg::CMDQ_DEPTH));
   assign accept = push && !full;

   always_comb begin
      wr_ptr_in = accept ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + bvfs_pkg::CMDQ_CNT_W'(accept)
                  - bvfs_pkg::CMDQ_CNT_W'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmdq_ff[wr_ptr_ff] <= cmd_in;
      end
   end

   assign cmd_link.valid = (count_ff != '0);
   assign cmd_link.cmd   = cmdq_ff[rd_ptr_ff];

endmodule

@@ sv/bvfs_lerp.sv @@
// Arithmetic pipeline: horizontal blend, vertical blend, truncation and result select.
module bvfs_lerp (
   input  logic               clock,
   input  logic               reset,
   input  bvfs_pkg::samp_type samp,
   output logic               res_valid,
   output bvfs_pkg::rsp_type  res
);

   logic signed [bvfs_pkg::DATA_W-1:0] vx [bvfs_pkg::BANK_COUNT];
   logic signed [bvfs_pkg::DATA_W-1:0] vy [bvfs_pkg::BANK_COUNT];
   logic signed [bvfs_pkg::WT_W:0]     wx [bvfs_pkg::BANK_COUNT];
   logic signed [bvfs_pkg::PROD_W-1:0] px [bvfs_pkg::BANK_COUNT];
   logic signed [bvfs_pkg::PROD_W-1:0] py [bvfs_pkg::BANK_COUNT];
   logic [bvfs_pkg::WT_W-1:0]          tx_w;
   logic [bvfs_pkg::WT_W-1:0]          ty_w;
   logic signed [bvfs_pkg::WT_W:0]     wy_top;
   logic signed [bvfs_pkg::WT_W:0]     wy_bot;
   logic signed [bvfs_pkg::PSUM_W-1:0] qx_top, qx_bot, qy_top, qy_bot;
   logic [bvfs_pkg::SUM_W-1:0]         bias_x, bias_y;
   logic [bvfs_pkg::SUM_W-1:0]         biased_x, biased_y;

   // Stage b: rows blended along x.
   logic                               b_valid_ff, b_valid_in;
   bvfs_pkg::act_type                  b_act_ff;
   logic                               b_inside_ff;
   logic [bvfs_pkg::FRAC_BITS-1:0]     b_ty_ff;
   logic [bvfs_pkg::RAM_W-1:0]         b_near_ff;
   logic signed [bvfs_pkg::ROW_W-1:0]  b_top_x_ff, b_top_x_in, b_bot_x_ff, b_bot_x_in;
   logic signed [bvfs_pkg::ROW_W-1:0]  b_top_y_ff, b_top_y_in, b_bot_y_ff, b_bot_y_in;

   // Stage c: full weighted sums.
   logic                               c_valid_ff, c_valid_in;
   bvfs_pkg::act_type                  c_act_ff;
   logic                               c_inside_ff;
   logic [bvfs_pkg::RAM_W-1:0]         c_near_ff;
   logic signed [bvfs_pkg::SUM_W-1:0]  c_sum_x_ff, c_sum_x_in, c_sum_y_ff, c_sum_y_in;

   // Stage d: finished result.
   logic                               d_valid_ff, d_valid_in;
   bvfs_pkg::rsp_type                  d_res_ff, d_res_in;

   assign tx_w = {1'b0, samp.meta.tx};
   assign ty_w = {1'b0, b_ty_ff};

   always_comb begin
      for (int c = 0; c < bvfs_pkg::BANK_COUNT; c++) begin
         vx[c] = samp.corner[c][bvfs_pkg::RAM_W-1:bvfs_pkg::DATA_W];
         vy[c] = samp.corner[c][bvfs_pkg::DATA_W-1:0];
         wx[c] = (c % 2 == 1) ? $signed({1'b0, tx_w})
                              : $signed({1'b0, bvfs_pkg::ONE_FIX - tx_w});
         px[c] = vx[c] * wx[c];
         py[c] = vy[c] * wx[c];
      end
      // Each row blend is a convex combination, so it fits ROW_W bits.
      b_top_x_in = bvfs_pkg::ROW_W'(px[0] + px[1]);
      b_bot_x_in = bvfs_pkg::ROW_W'(px[2] + px[3]);
      b_top_y_in = bvfs_pkg::ROW_W'(py[0] + py[1]);
      b_bot_y_in = bvfs_pkg::ROW_W'(py[2] + py[3]);
      b_valid_in = samp.valid;
   end

   always_comb begin
      wy_top     = $signed({1'b0, bvfs_pkg::ONE_FIX - ty_w});
      wy_bot     = $signed({1'b0, ty_w});
      qx_top     = b_top_x_ff * wy_top;
      qx_bot     = b_bot_x_ff * wy_bot;
      qy_top     = b_top_y_ff * wy_top;
      qy_bot     = b_bot_y_ff * wy_bot;
      c_sum_x_in = bvfs_pkg::SUM_W'(qx_top + qx_bot);
      c_sum_y_in = bvfs_pkg::SUM_W'(qy_top + qy_bot);
      c_valid_in = b_valid_ff;
   end

   // Dividing by ONE squared truncates toward zero: a negative sum is biased
   // up before the arithmetic shift.
   always_comb begin
      bias_x   = c_sum_x_ff[bvfs_pkg::SUM_W-1] ? bvfs_pkg::TRUNC_BIAS : '0;
      bias_y   = c_sum_y_ff[bvfs_pkg::SUM_W-1] ? bvfs_pkg::TRUNC_BIAS : '0;
      biased_x = c_sum_x_ff + bias_x;
      biased_y = c_sum_y_ff + bias_y;

      d_res_in.vec_x      = '0;
      d_res_in.vec_y      = '0;
      d_res_in.inside_res = c_inside_ff;
      case (c_act_ff)
         bvfs_pkg::ACT_NEAREST: begin
            if (c_inside_ff) begin
               d_res_in.vec_x = c_near_ff[bvfs_pkg::RAM_W-1:bvfs_pkg::DATA_W];
               d_res_in.vec_y = c_near_ff[bvfs_pkg::DATA_W-1:0];
            end
         end
         bvfs_pkg::ACT_BILINEAR: begin
            if (c_inside_ff) begin
               d_res_in.vec_x = biased_x[bvfs_pkg::SUM_W-1:2*bvfs_pkg::FRAC_BITS];
               d_res_in.vec_y = biased_y[bvfs_pkg::SUM_W-1:2*bvfs_pkg::FRAC_BITS];
            end
         end
         default: begin
            d_res_in.vec_x = '0;
            d_res_in.vec_y = '0;
         end
      endcase
      d_valid_in = c_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
         d_valid_ff <= d_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b_act_ff    <= samp.meta.act;
      b_inside_ff <= samp.meta.in_bounds;
      b_ty_ff     <= samp.meta.ty;
      b_near_ff   <= samp.corner[0];
      b_top_x_ff  <= b_top_x_in;
      b_bot_x_ff  <= b_bot_x_in;
      b_top_y_ff  <= b_top_y_in;
      b_bot_y_ff  <= b_bot_y_in;
      c_act_ff    <= b_act_ff;
      c_inside_ff <= b_inside_ff;
      c_near_ff   <= b_near_ff;
      c_sum_x_ff  <= c_sum_x_in;
      c_sum_y_ff  <= c_sum_y_in;
      d_res_ff    <= d_res_in;
   end

   assign res_valid = d_valid_ff;
   assign res       = d_res_ff;

endmodule

@@ sv/bvfs_back.sv @@
// Back end: issues commands to the banked grid, runs the blend pipeline, queues results.
module bvfs_back (
   input  logic                   clock,
   input  logic                   reset,
   input  bvfs_pkg::cmd_link_type cmd_link,
   output logic                   cmd_pop,
   output logic                   empty,
   input  logic                   pop,
   output bvfs_pkg::rsp_type      rsp_data
);

   bvfs_pkg::cmd_type                          cmd;
   logic                                       issue;
   logic                                       bank_write;
   logic                                       rsp_take;
   logic [bvfs_pkg::BANK_COL_W-1:0]            even_col, odd_col;
   logic [bvfs_pkg::BANK_ROW_W-1:0]            even_row, odd_row;
   logic [bvfs_pkg::BANK_COUNT-1:0][bvfs_pkg::RAM_W-1:0] bank_rd;
   logic [1:0]                                 odd_sel;

   logic                                       a_valid_ff, a_valid_in;
   bvfs_pkg::meta_type                         a_meta_ff, a_meta_in;
   bvfs_pkg::samp_type                         samp;
   logic                                       res_valid;
   bvfs_pkg::rsp_type                          res;

   logic [bvfs_pkg::RSPQ_CNT_W-1:0]            credit_ff, credit_in;
   bvfs_pkg::rsp_type                          rspq_ff [bvfs_pkg::RSPQ_DEPTH];
   logic [bvfs_pkg::RSPQ_PTR_W-1:0]            wr_ptr_ff, wr_ptr_in;
   logic [bvfs_pkg::RSPQ_PTR_W-1:0]            rd_ptr_ff, rd_ptr_in;
   logic [bvfs_pkg::RSPQ_CNT_W-1:0]            count_ff, count_in;

   assign cmd = cmd_link.cmd;

   // Every item issued holds a result queue slot until its result is taken,
   // so the pipeline never has to stall.
   assign issue      = cmd_link.valid
                       && (credit_ff < bvfs_pkg::RSPQ_CNT_W'(bvfs_pkg::RSPQ_DEPTH));
   assign cmd_pop    = issue;
   assign bank_write = issue && (cmd.act == bvfs_pkg::ACT_WRITE) && cmd.in_bounds;

   // An even-parity bank holds the neighbor at x0 or x0+1, whichever is even.
   assign even_col = bvfs_pkg::BANK_COL_W'(({1'b0, cmd.x0} + 1'b1) >> 1);
   assign odd_col  = bvfs_pkg::BANK_COL_W'(cmd.x0 >> 1);
   assign even_row = bvfs_pkg::BANK_ROW_W'(({1'b0, cmd.y0} + 1'b1) >> 1);
   assign odd_row  = bvfs_pkg::BANK_ROW_W'(cmd.y0 >> 1);

   for (genvar b = 0; b < bvfs_pkg::BANK_COUNT; b++) begin : g_bank
      logic [bvfs_pkg::BANK_COL_W-1:0]  col;
      logic [bvfs_pkg::BANK_ROW_W-1:0]  row;
      logic [bvfs_pkg::BANK_ADDR_W-1:0] addr;
      logic                             wr_en;

      assign col   = (b % 2 == 0) ? even_col : odd_col;
      assign row   = (b / 2 == 0) ? even_row : odd_row;
      assign addr  = {row, col};
      assign wr_en = bank_write && (cmd.x0[0] == 1'(b % 2)) && (cmd.y0[0] == 1'(b / 2));

      bvfs_ram #(
         .WIDTH(bvfs_pkg::RAM_W),
         .DEPTH(bvfs_pkg::BANK_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (addr),
         .wr_data ({cmd.value_x, cmd.value_y}),
         .rd_addr (addr),
         .rd_data (bank_rd[b])
      );
   end

   always_comb begin
      a_valid_in          = issue;
      a_meta_in.act       = cmd.act;
      a_meta_in.in_bounds = cmd.in_bounds;
      a_meta_in.x_odd     = cmd.x0[0];
      a_meta_in.y_odd     = cmd.y0[0];
      a_meta_in.tx        = cmd.tx;
      a_meta_in.ty        = cmd.ty;
   end

   // Put the bank outputs back into corner order using the parity of x0 and y0.
   assign odd_sel = {a_meta_ff.y_odd, a_meta_ff.x_odd};

   always_comb begin
      samp.valid = a_valid_ff;
      samp.meta  = a_meta_ff;
      for (int c = 0; c < bvfs_pkg::BANK_COUNT; c++) begin
         samp.corner[c] = bank_rd[2'(c) ^ odd_sel];
      end
   end

   bvfs_lerp u_lerp (
      .clock     (clock),
      .reset     (reset),
      .samp      (samp),
      .res_valid (res_valid),
      .res       (res)
   );

   assign empty    = (count_ff == '0);
   assign rsp_take = pop && !empty;
   assign rsp_data = rspq_ff[rd_ptr_ff];

   always_comb begin
      credit_in = credit_ff + bvfs_pkg::RSPQ_CNT_W'(issue)
                  - bvfs_pkg::RSPQ_CNT_W'(rsp_take);
      wr_ptr_in = res_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = rsp_take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + bvfs_pkg::RSPQ_CNT_W'(res_valid)
                  - bvfs_pkg::RSPQ_CNT_W'(rsp_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         credit_ff  <= '0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         count_ff   <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         credit_ff  <= credit_in;
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      a_meta_ff <= a_meta_in;
      if (res_valid) begin
         rspq_ff[wr_ptr_ff] <= res;
      end
   end

endmodule

@@ sv/bilinear_vector_field_sampler.sv @@
// Top level of the bilinear vector field sampler: front end, back end and checks.
//
//   Channel   Ports                   Direction   Accepted when
//   request   push, full, req_data    in          push && !full
//   result    empty, pop, rsp_data    out         pop && !empty
//
// One item per cycle sustained while results are popped as they come; every item gives
// one result (command queue, bank read, x blend, y blend, truncation, result queue).
// Four parity banks give the four neighbors of a sample in a single read.
// Reset clears the queues and pipeline valids; grid cells are undefined until written.
// A 4-item command queue and an 8-item result queue let each side stall alone;
// issue pauses while eight results are owed to the result side.
module bilinear_vector_field_sampler (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  bvfs_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output bvfs_pkg::rsp_type rsp_data
);

   bvfs_pkg::cmd_link_type cmd_link;
   logic                   cmd_pop;

   bvfs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .cmd_pop  (cmd_pop),
      .cmd_link (cmd_link)
   );

   bvfs_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_link (cmd_link),
      .cmd_pop  (cmd_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_empty_after_reset: assert property (@(posedge clock) reset |=> empty)
      else $error("result queue holds an item right after reset");

   a_pop_only_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_link.valid)
      else $error("back end took a command from an empty queue");

   a_push_reaches_queue: assert property (@(posedge clock) disable iff (reset)
      (push && !full) |=> cmd_link.valid)
      else $error("accepted item did not appear in the command queue");
`endif

endmodule
